>>> hw/rtl/ppid_pkg.sv
// Shared types and register map for the clamped positional PID controller.
`timescale 1ns / 1ps
`default_nettype none

package ppid_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_P_GAIN    = 3'd0;
	localparam reg_idx_t REG_I_GAIN    = 3'd1;
	localparam reg_idx_t REG_D_GAIN    = 3'd2;
	localparam reg_idx_t REG_INT_LIMIT = 3'd3;
	localparam reg_idx_t REG_OUT_LIMIT = 3'd4;

	localparam logic [29:0] INT_LIMIT_RST = 30'd1000000;
	localparam logic [14:0] OUT_LIMIT_RST = 15'd32767;

	// Widths of the datapath
	localparam int unsigned ERR_W  = 17;
	localparam int unsigned DIFF_W = 18;
	localparam int unsigned INT_W  = 32;
	localparam int unsigned ACC_W  = 50;
	localparam int unsigned SHR_W  = ACC_W - 8;

endpackage

`default_nettype wire

>>> hw/rtl/positional_pid_clamped.sv
// Top level of the clamped positional PID controller: config registers and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Signals                                   | Direction | Payload
// ----------+-------------------------------------------+-----------+-----------------------
// request   | in_valid, in_ready, setpoint, measured    | in        | 16b signed x2
// result    | out_valid, out_ready, drive               | out       | 16b signed
// config    | psel, penable, pwrite, paddr, pwdata,     | in/out    | 5 regs at 4*i
//           | prdata, pready                            |           |
//
// Throughput: one request per clock while out_ready stays high; a taken request goes
// into the input stage register, then into the result register once that is free or
// drained (input stage, then result register).
// The combinational path between the stage register and the result register holds the
// three gain multiplies, the sum, the shift and the clamps; the integral and the
// previous error feed back through that same path.
// Reset: arst_n clears the pipeline, the integral and the previous error, and
// loads the register defaults.
// Stalls: a held result blocks the input stage only when that stage is also full.
module positional_pid_clamped
	import ppid_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request channel
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic signed [15:0]  setpoint,
	input  wire logic signed [15:0]  measured,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [15:0]       drive,
	// config port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [ADDR_W-1:0]   paddr,
	input  wire logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	// Config registers
	logic [15:0] p_gain_q;
	logic [15:0] i_gain_q;
	logic [15:0] d_gain_q;
	logic [29:0] int_limit_q;
	logic [14:0] out_limit_q;

	// Input stage
	logic                    valid_s1;
	logic signed [15:0]      setpoint_s1;
	logic signed [15:0]      measured_s1;

	// Loop state
	logic signed [INT_W-1:0] integral_q;
	logic signed [ERR_W-1:0] prev_err_q;

	// Result register
	logic                    out_valid_q;
	logic signed [15:0]      drive_q;

	// Datapath
	logic                    advance;
	logic                    cfg_wr;
	logic signed [ERR_W-1:0] err;
	logic signed [DIFF_W-1:0] err_diff;
	logic signed [INT_W-1:0] int_base;
	logic signed [INT_W-1:0] int_lim_pos;
	logic signed [INT_W-1:0] int_lim_neg;
	logic signed [INT_W-1:0] int_clamped;
	logic signed [INT_W:0]   int_sum_wide;
	logic signed [INT_W-1:0] int_next;
	logic signed [33:0]      p_term;
	logic signed [48:0]      i_term;
	logic signed [34:0]      d_term;
	logic signed [ACC_W-1:0] acc;
	logic signed [SHR_W-1:0] acc_shr;
	logic signed [SHR_W-1:0] olim_pos;
	logic signed [SHR_W-1:0] olim_neg;
	logic signed [15:0]      drive_next;

	// Move the staged request into the result register whenever it is free or drained.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// Config port: zero wait states, write on the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_P_GAIN:    prdata = {16'd0, p_gain_q};
			REG_I_GAIN:    prdata = {16'd0, i_gain_q};
			REG_D_GAIN:    prdata = {16'd0, d_gain_q};
			REG_INT_LIMIT: prdata = {2'd0, int_limit_q};
			REG_OUT_LIMIT: prdata = {17'd0, out_limit_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q    <= '0;
			i_gain_q    <= '0;
			d_gain_q    <= '0;
			int_limit_q <= INT_LIMIT_RST;
			out_limit_q <= OUT_LIMIT_RST;
		end else if (cfg_wr) begin
			case (paddr[ADDR_W-1:2])
				REG_P_GAIN:    p_gain_q    <= pwdata[15:0];
				REG_I_GAIN:    i_gain_q    <= pwdata[15:0];
				REG_D_GAIN:    d_gain_q    <= pwdata[15:0];
				REG_INT_LIMIT: int_limit_q <= pwdata[29:0];
				REG_OUT_LIMIT: out_limit_q <= pwdata[14:0];
				default: begin
					// drop writes to unmapped addresses
				end
			endcase
		end
	end

	// Error and its change since the last request
	assign err      = {setpoint_s1[15], setpoint_s1} - {measured_s1[15], measured_s1};
	assign err_diff = {err[ERR_W-1], err} - {prev_err_q[ERR_W-1], prev_err_q};

	// Integral: clear on zero feedback, clamp the stored value, then add the error.
	// The result stays within 2^30 - 1 + 2^16, so 32 bits always hold it.
	assign int_base    = (measured_s1 == 16'sd0) ? '0 : integral_q;
	assign int_lim_pos = $signed({2'b00, int_limit_q});
	assign int_lim_neg = -int_lim_pos;

	always_comb begin
		if (int_base > int_lim_pos) begin
			int_clamped = int_lim_pos;
		end else if (int_base < int_lim_neg) begin
			int_clamped = int_lim_neg;
		end else begin
			int_clamped = int_base;
		end
	end

	assign int_sum_wide = {int_clamped[INT_W-1], int_clamped}
	                    + {{(INT_W+1-ERR_W){err[ERR_W-1]}}, err};
	assign int_next     = int_sum_wide[INT_W-1:0];

	// Gain products: unsigned Q8.8 gains against signed operands, exact in Q.8
	assign p_term = $signed({1'b0, p_gain_q}) * err;
	assign i_term = $signed({1'b0, i_gain_q}) * int_next;
	assign d_term = $signed({1'b0, d_gain_q}) * err_diff;

	assign acc = {{(ACC_W-34){p_term[33]}}, p_term}
	           + {{(ACC_W-49){i_term[48]}}, i_term}
	           + {{(ACC_W-35){d_term[34]}}, d_term};

	// Arithmetic shift by 8 rounds toward minus infinity
	assign acc_shr  = acc[ACC_W-1:8];
	assign olim_pos = $signed({{(SHR_W-15){1'b0}}, out_limit_q});
	assign olim_neg = -olim_pos;

	always_comb begin
		if (acc_shr > olim_pos) begin
			drive_next = $signed({1'b0, out_limit_q});
		end else if (acc_shr < olim_neg) begin
			drive_next = -$signed({1'b0, out_limit_q});
		end else begin
			drive_next = acc_shr[15:0];
		end
	end

	// Control: stage valid, result valid, loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			integral_q  <= '0;
			prev_err_q  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				out_valid_q <= 1'b1;
				integral_q  <= int_next;
				prev_err_q  <= err;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: hold the staged request and the result until they move on
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			setpoint_s1 <= setpoint;
			measured_s1 <= measured;
		end
		if (advance) begin
			drive_q <= drive_next;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ppid_checker.sv
// Port-level checker for the clamped positional PID controller and its bind.
`timescale 1ns / 1ps
`default_nettype none

module ppid_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] drive,
	input wire logic        pready
);

	// Result is clamped symmetrically, so the most negative code never appears.
	a_drive_symmetric: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive != 16'h8000)
		else $error("drive left the symmetric clamp range");

	// With the result register empty, the block must take a request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused while result register is empty");

	// A stalled result holds.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive))
		else $error("stalled result changed or vanished");

	// Config port never inserts wait states.
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind positional_pid_clamped ppid_checker u_ppid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.drive     (drive),
	.pready    (pready)
);

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the clamped positional PID controller.
`timescale 1ns / 1ps

module tb_top;
	import ppid_pkg::*;

	// Byte addresses of the register map, plus a few that decode to no register
	localparam logic [ADDR_W-1:0] ADDR_P_GAIN     = {REG_P_GAIN, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_I_GAIN     = {REG_I_GAIN, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_D_GAIN     = {REG_D_GAIN, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_INT_LIM    = {REG_INT_LIMIT, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_OUT_LIM    = {REG_OUT_LIMIT, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_UNUSED_LO  = 5'd20;
	localparam logic [ADDR_W-1:0] ADDR_UNUSED_MID = 5'd24;
	localparam logic [ADDR_W-1:0] ADDR_UNUSED_HI  = 5'd28;

	localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
	localparam logic signed [15:0] S16_MIN = 16'sh8000;
	localparam logic [31:0]        ALL_ONES = 32'hFFFF_FFFF;

	localparam int N_PLAN          = 33;
	localparam int N_PHASES        = 8;
	localparam int REQS_PER_PHASE  = 190;
	localparam int SETTLE_CYCLES   = 4;

	typedef enum bit {ROW_REQ, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       wdata;
		logic signed [15:0] sp;
		logic signed [15:0] ms;
		logic              pinned;   // drive value below is known without the predictor
		logic signed [15:0] want;
	} plan_row_t;

	// Directed part: corner requests and register writes, in order.
	plan_row_t plan [N_PLAN] = '{
		// all gains zero after reset: drive stays at zero
		'{ROW_REQ,   5'd0,         32'd0,        S16_MAX,   S16_MIN,    1'b1, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        S16_MIN,   S16_MAX,    1'b1, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        16'sd0,    16'sd0,     1'b1, 16'sd0},
		// full proportional gain with junk in the upper bits: saturate both ways
		'{ROW_WRITE, ADDR_P_GAIN,  ALL_ONES,     16'sd0,    16'sd0,     1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        S16_MAX,   S16_MIN,    1'b1, 16'sd32767},
		'{ROW_REQ,   5'd0,         32'd0,        S16_MIN,   S16_MAX,    1'b1, -16'sd32767},
		// zero output limit forces zero drive
		'{ROW_WRITE, ADDR_OUT_LIM, 32'd0,        16'sd0,    16'sd0,     1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        16'sd100,  16'sd5,     1'b1, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        S16_MIN,   S16_MAX,    1'b1, 16'sd0},
		'{ROW_WRITE, ADDR_OUT_LIM, ALL_ONES,     16'sd0,    16'sd0,     1'b0, 16'sd0},
		// all gains at maximum, zero integral limit: integral tracks the error
		'{ROW_WRITE, ADDR_I_GAIN,  32'h0000_FFFF, 16'sd0,   16'sd0,     1'b0, 16'sd0},
		'{ROW_WRITE, ADDR_D_GAIN,  32'h0001_FFFF, 16'sd0,   16'sd0,     1'b0, 16'sd0},
		'{ROW_WRITE, ADDR_INT_LIM, 32'd0,        16'sd0,    16'sd0,     1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        16'sd1000, 16'sd0,     1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        16'sd0,    16'sd1000,  1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        -16'sd1,   16'sd1,     1'b0, 16'sd0},
		// widest integral limit, then modest gains so drive stays unsaturated
		'{ROW_WRITE, ADDR_INT_LIM, ALL_ONES,     16'sd0,    16'sd0,     1'b0, 16'sd0},
		'{ROW_WRITE, ADDR_P_GAIN,  32'h0000_0100, 16'sd0,   16'sd0,     1'b0, 16'sd0},
		'{ROW_WRITE, ADDR_I_GAIN,  32'h0000_0001, 16'sd0,   16'sd0,     1'b0, 16'sd0},
		'{ROW_WRITE, ADDR_D_GAIN,  32'h0000_0080, 16'sd0,   16'sd0,     1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        16'sd5,    16'sd3,     1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        -16'sd5,   16'sd3,     1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        16'sd0,    -16'sd1,    1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        S16_MAX,   S16_MAX,    1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        S16_MIN,   S16_MIN,    1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        16'sd1,    16'sd0,     1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        16'sd0,    16'sd1,     1'b0, 16'sd0},
		// writes outside the map must leave every register alone
		'{ROW_WRITE, ADDR_UNUSED_LO, ALL_ONES,   16'sd0,    16'sd0,     1'b0, 16'sd0},
		'{ROW_WRITE, ADDR_UNUSED_HI, 32'h1234_5678, 16'sd0, 16'sd0,     1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        16'sd300,  -16'sd300,  1'b0, 16'sd0},
		// output limit of one
		'{ROW_WRITE, ADDR_OUT_LIM, 32'd1,        16'sd0,    16'sd0,     1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        16'sd100,  -16'sd100,  1'b0, 16'sd0},
		'{ROW_REQ,   5'd0,         32'd0,        -16'sd100, 16'sd100,   1'b0, 16'sd0}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [15:0]       setpoint;
	logic signed [15:0]       measured;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [15:0]       drive;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_W-1:0]        paddr;
	logic [DATA_W-1:0]        pwdata;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;

	// Mirror of the register file and of the controller state
	logic [15:0]              kp = 16'd0;
	logic [15:0]              ki = 16'd0;
	logic [15:0]              kd = 16'd0;
	logic [29:0]              ilim = INT_LIMIT_RST;
	logic [14:0]              olim = OUT_LIMIT_RST;
	longint                   integ = 0;
	longint                   prev_err = 0;

	logic signed [15:0]       drive_q [$];   // drive values still owed by the block
	bit                       calm = 1'b0;   // no idling on either side while set
	int                       n_errors = 0;
	int                       n_reqs = 0;
	int                       n_drives = 0;
	int                       n_writes = 0;

	positional_pid_clamped u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.setpoint  (setpoint),
		.measured  (measured),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the controller mirror by one request and return the drive it owes.
	function automatic logic signed [15:0] pid_step(input logic signed [15:0] sp,
			input logic signed [15:0] ms);
		longint err;
		longint lim;
		longint acc;
		longint lvl;
		err = longint'(sp) - longint'(ms);
		lim = longint'(ilim);
		// measured of zero drops the accumulated integral
		if (ms == 16'sd0)
			integ = 0;
		// clamp the stored integral first, then add the fresh error
		if (integ > lim)
			integ = lim;
		else if (integ < -lim)
			integ = -lim;
		integ = integ + err;
		acc = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * (err - prev_err);
		prev_err = err;
		// arithmetic shift floors toward minus infinity
		lvl = acc >>> 8;
		if (lvl > longint'(olim))
			lvl = longint'(olim);
		else if (lvl < -longint'(olim))
			lvl = -longint'(olim);
		return lvl[15:0];
	endfunction

	// Mostly short gaps, some medium, a few long ones; no gap while calm is set.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Field values biased toward extremes and small magnitudes.
	function automatic logic signed [15:0] pick_s16();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			case ($urandom_range(0, 4))
				0: return S16_MIN;
				1: return S16_MAX;
				2: return 16'sd0;
				3: return -16'sd1;
				default: return 16'sd1;
			endcase
		end
		if (r < 45)
			return 16'(int'($urandom_range(0, 512)) - 256);
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] reg_value(input reg_idx_t idx);
		case (idx)
			REG_P_GAIN:    return 32'(kp);
			REG_I_GAIN:    return 32'(ki);
			REG_D_GAIN:    return 32'(kd);
			REG_INT_LIMIT: return 32'(ilim);
			REG_OUT_LIMIT: return 32'(olim);
			default:       return 32'd0;
		endcase
	endfunction

	// Present one request after a random gap, hold it until taken, then log its drive.
	task automatic send_req(input logic signed [15:0] sp, input logic signed [15:0] ms,
			input logic pinned, input logic signed [15:0] want);
		int gap;
		logic signed [15:0] pred;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		setpoint = sp;
		measured = ms;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		pred = pid_step(sp, ms);
		drive_q.push_back(pinned ? want : pred);
		n_reqs++;
	endtask

	// Drop the request valid and let the pipeline drain.
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic [ADDR_W-1:0] a, input logic wr,
			input logic [31:0] wd, output logic [31:0] rd);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = a;
		pwdata = wd;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic check_reg(input reg_idx_t idx);
		logic [31:0] rd;
		apb_xfer({idx, 2'b00}, 1'b0, 32'd0, rd);
		if (rd !== reg_value(idx)) begin
			$error("register %0d: expected %0h, got %0h", idx, reg_value(idx), rd);
			n_errors++;
		end
	endtask

	// Write a register only with the block idle, mirror it, and read back a mapped one.
	task automatic set_reg(input logic [ADDR_W-1:0] a, input logic [31:0] wd);
		logic [31:0] rd;
		wait_idle();
		apb_xfer(a, 1'b1, wd, rd);
		case (reg_idx_t'(a[4:2]))
			REG_P_GAIN:    kp = wd[15:0];
			REG_I_GAIN:    ki = wd[15:0];
			REG_D_GAIN:    kd = wd[15:0];
			REG_INT_LIMIT: ilim = wd[29:0];
			REG_OUT_LIMIT: olim = wd[14:0];
			default: ;
		endcase
		if (a[4:2] <= REG_OUT_LIMIT)
			check_reg(reg_idx_t'(a[4:2]));
		n_writes++;
	endtask

	// Result side: stall the receiver with random gaps, with ready runs between.
	initial begin
		int gap;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = 1'b1;
			repeat ($urandom_range(0, 7)) @(negedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				@(negedge clk);
				out_ready = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	// Compare every accepted drive with the oldest one owed.
	initial begin
		logic signed [15:0] exp_drive;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (drive_q.size() == 0) begin
					$error("drive: no result expected, got %0d", drive);
					n_errors++;
				end else begin
					exp_drive = drive_q.pop_front();
					n_drives++;
					if (drive !== exp_drive) begin
						$error("drive: expected %0d, got %0d", exp_drive, drive);
						n_errors++;
					end
				end
			end
		end
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic signed [15:0] sp;
		logic signed [15:0] ms;
		logic [15:0] g_p;
		logic [15:0] g_i;
		logic [15:0] g_d;
		logic [29:0] l_i;
		logic [14:0] l_o;
		int run_left;
		int msi;
		int r;
		logic [ADDR_W-1:0] junk_addr;

		// Drive every input to a known value and hold reset, then release it
		arst_n = 1'b0;
		in_valid = 1'b0;
		setpoint = 16'sd0;
		measured = 16'sd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults must read back before anything is written
		for (int i = 0; i <= int'(REG_OUT_LIMIT); i++)
			check_reg(reg_idx_t'(i));

		// Walk the directed table
		for (int i = 0; i < N_PLAN; i++) begin
			if (plan[i].kind == ROW_WRITE)
				set_reg(plan[i].addr, plan[i].wdata);
			else
				send_req(plan[i].sp, plan[i].ms, plan[i].pinned, plan[i].want);
		end

		// Random phases, each under its own register setting
		sp = 16'sd0;
		ms = 16'sd0;
		run_left = 0;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			calm = 1'b0;
			g_p = 16'($urandom);
			g_i = 16'($urandom);
			g_d = 16'($urandom);
			l_i = INT_LIMIT_RST;
			l_o = OUT_LIMIT_RST;
			case (ph)
				1: begin
					// full gains, integral pinned to the current error
					g_p = 16'hFFFF;
					g_i = 16'hFFFF;
					g_d = 16'hFFFF;
					l_i = 30'd0;
				end
				2: begin
					g_p = 16'($urandom_range(0, 16'h200));
					g_i = 16'($urandom_range(0, 16'h20));
					g_d = 16'($urandom_range(0, 16'h200));
					l_i = 30'($urandom_range(0, 100000));
					l_o = 15'($urandom);
				end
				3: begin
					g_p = 16'd0;
					g_i = 16'd0;
					g_d = 16'd0;
					l_o = 15'($urandom);
				end
				4: begin
					// widest integral bound, output held at zero
					g_p = 16'hFFFF;
					g_i = 16'hFFFF;
					g_d = 16'hFFFF;
					l_i = 30'h3FFF_FFFF;
					l_o = 15'd0;
				end
				5: begin
					l_i = 30'($urandom);
					l_o = 15'($urandom);
				end
				6: begin
					// integral-only loop with a tight clamp
					g_p = 16'd0;
					g_i = 16'($urandom_range(1, 16'h40));
					g_d = 16'd0;
					l_i = 30'($urandom_range(1, 5000));
				end
				7: begin
					l_i = 30'($urandom_range(0, 300000));
					l_o = 15'd1;
				end
				default: ;
			endcase
			// keep random junk above each register's width
			set_reg(ADDR_P_GAIN, (32'($urandom) << 16) | 32'(g_p));
			set_reg(ADDR_I_GAIN, (32'($urandom) << 16) | 32'(g_i));
			set_reg(ADDR_D_GAIN, (32'($urandom) << 16) | 32'(g_d));
			set_reg(ADDR_INT_LIM, (32'($urandom) << 30) | 32'(l_i));
			set_reg(ADDR_OUT_LIM, (32'($urandom) << 15) | 32'(l_o));
			case ($urandom_range(0, 2))
				0: junk_addr = ADDR_UNUSED_LO;
				1: junk_addr = ADDR_UNUSED_MID;
				default: junk_addr = ADDR_UNUSED_HI;
			endcase
			set_reg(junk_addr, $urandom);
			calm = (ph % 3 == 2);

			for (int k = 0; k < REQS_PER_PHASE; k++) begin
				// hold the setpoint for a run, as a real loop would
				if (run_left == 0) begin
					sp = pick_s16();
					run_left = $urandom_range(1, 30);
				end
				run_left--;
				r = $urandom_range(0, 99);
				if (r < 10) begin
					ms = 16'sd0;
				end else if (r < 25) begin
					ms = pick_s16();
				end else if (r < 75) begin
					// track toward the setpoint with a little noise
					msi = int'(ms) + ((int'(sp) - int'(ms)) >>> 2)
						+ int'($urandom_range(0, 16)) - 8;
					if (msi > 32767)
						msi = 32767;
					else if (msi < -32768)
						msi = -32768;
					ms = 16'(msi);
				end else begin
					ms = 16'($urandom);
				end
				send_req(sp, ms, 1'b0, 16'sd0);
			end
		end

		// Drain and give the pipeline a few spare cycles
		@(negedge clk);
		in_valid = 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run covered %0d requests and %0d register writes over %0d gain settings.",
			n_reqs, n_writes, N_PHASES);
		$display("Checked %0d drive results, %0d mismatches.", n_drives, n_errors);
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/ppid_pkg.sv
hw/rtl/positional_pid_clamped.sv
hw/rtl/ppid_checker.sv
verif/tb_top.sv
